[rtl/core/assert_macros.svh]
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ekt_pkg.sv]
// shared types, constants and helper functions of the expiring key table
package ekt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W   = 64;
    localparam int TIME_W  = 48;
    localparam int HOLD_W  = 24;
    localparam int COUNT_W = 5;
    localparam int COUNT_MAX = 31;

    localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(86400);

    localparam int S_TDATA_W = KEY_W + TIME_W;
    localparam int M_TDATA_W = 16;
    localparam int CMD_W     = 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SWEEP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] expiry;
    } entry_t;

    typedef struct packed {
        logic                   match_found;
        logic [IDX_W-1:0]       match_idx;
        logic [TIME_W-1:0]      match_exp;
        logic [TABLE_DEPTH-1:0] exp_mask;
        logic [CNT_W-1:0]       exp_cnt;
        logic [IDX_W-1:0]       min_idx;
    } scan_res_t;

    typedef struct packed {
        logic             any;
        logic [IDX_W-1:0] idx;
    } pick_t;

    function automatic pick_t lowest_set(input logic [TABLE_DEPTH-1:0] m);
        pick_t p;
        p = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                p.any = 1'b1;
                p.idx = IDX_W'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] n);
        if (32'(n) > 32'(COUNT_MAX))
            return COUNT_W'(COUNT_MAX);
        else
            return COUNT_W'(n);
    endfunction

    function automatic logic [TIME_W-1:0] expiry_of(input logic [TIME_W-1:0] now,
                                                   input logic [HOLD_W-1:0] hold);
        logic [TIME_W:0] sum;
        sum = {1'b0, now} + (TIME_W + 1)'(hold);
        if (sum[TIME_W])
            return '1;
        else
            return sum[TIME_W-1:0];
    endfunction

endpackage

[rtl/core/ekt_store.sv]
// key and expiry memory with one write port and one registered read port
module ekt_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       we,
    input  logic [ekt_pkg::IDX_W-1:0]  waddr,
    input  ekt_pkg::entry_t            wdata,
    input  logic                       re,
    input  logic [ekt_pkg::IDX_W-1:0]  raddr,
    output logic                       rd_vld,
    output logic [ekt_pkg::IDX_W-1:0]  rd_idx,
    output ekt_pkg::entry_t            rd_entry
);
    import ekt_pkg::*;

    entry_t           mem [TABLE_DEPTH];
    entry_t           rdata_reg;
    logic [IDX_W-1:0] ridx_reg;
    logic             rvld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
        ridx_reg  <= raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rvld_reg <= 1'b0;
        else
            rvld_reg <= re;
    end

    assign rd_vld   = rvld_reg;
    assign rd_idx   = ridx_reg;
    assign rd_entry = rdata_reg;

endmodule

[rtl/core/ekt_scan.sv]
// per-slot scan: key match, expired mask and count, earliest expiry
module ekt_scan (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             rd_vld,
    input  logic [ekt_pkg::IDX_W-1:0]        rd_idx,
    input  ekt_pkg::entry_t                  rd_entry,
    input  logic [ekt_pkg::TABLE_DEPTH-1:0]  slot_valid,
    input  logic [ekt_pkg::KEY_W-1:0]        key,
    input  logic [ekt_pkg::TIME_W-1:0]       now_time,
    output ekt_pkg::scan_res_t               res
);
    import ekt_pkg::*;

    logic                   match_found_reg, match_found_next;
    logic [IDX_W-1:0]       match_idx_reg, match_idx_next;
    logic [TIME_W-1:0]      match_exp_reg, match_exp_next;
    logic [TABLE_DEPTH-1:0] exp_mask_reg, exp_mask_next;
    logic [CNT_W-1:0]       exp_cnt_reg, exp_cnt_next;
    logic                   min_found_reg, min_found_next;
    logic [IDX_W-1:0]       min_idx_reg, min_idx_next;
    logic [TIME_W-1:0]      min_exp_reg, min_exp_next;
    logic                   hit;

    assign hit = rd_vld && slot_valid[rd_idx];

    always_comb
    begin
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_exp_next   = match_exp_reg;
        exp_mask_next    = exp_mask_reg;
        exp_cnt_next     = exp_cnt_reg;
        min_found_next   = min_found_reg;
        min_idx_next     = min_idx_reg;
        min_exp_next     = min_exp_reg;
        if (start)
        begin
            match_found_next = 1'b0;
            exp_mask_next    = '0;
            exp_cnt_next     = '0;
            min_found_next   = 1'b0;
        end
        else if (hit)
        begin
            if (!match_found_reg && rd_entry.key == key)
            begin
                match_found_next = 1'b1;
                match_idx_next   = rd_idx;
                match_exp_next   = rd_entry.expiry;
            end
            if (now_time >= rd_entry.expiry)
            begin
                exp_mask_next[rd_idx] = 1'b1;
                exp_cnt_next          = exp_cnt_reg + CNT_W'(1);
            end
            // strict compare keeps the lowest slot on a tie
            if (!min_found_reg || rd_entry.expiry < min_exp_reg)
            begin
                min_found_next = 1'b1;
                min_idx_next   = rd_idx;
                min_exp_next   = rd_entry.expiry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            exp_mask_reg    <= '0;
            exp_cnt_reg     <= '0;
            min_found_reg   <= 1'b0;
        end
        else
        begin
            match_found_reg <= match_found_next;
            exp_mask_reg    <= exp_mask_next;
            exp_cnt_reg     <= exp_cnt_next;
            min_found_reg   <= min_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg <= match_idx_next;
        match_exp_reg <= match_exp_next;
        min_idx_reg   <= min_idx_next;
        min_exp_reg   <= min_exp_next;
    end

    assign res.match_found = match_found_reg;
    assign res.match_idx   = match_idx_reg;
    assign res.match_exp   = match_exp_reg;
    assign res.exp_mask    = exp_mask_reg;
    assign res.exp_cnt     = exp_cnt_reg;
    assign res.min_idx     = min_idx_reg;

endmodule

[rtl/core/expiring_key_table_with_eviction_unit.sv]
// expiring key table: control sequencer, valid bits, config register, output stage
// an item goes from accept through scan, drain and decide; decide waits while the output holds an untaken result
// a new item is taken only in idle, once the last result is loaded; the scan reads one memory slot per cycle
// a clear skips the scan and drain and goes straight from accept to the decide step
// async active-low reset empties the table and sets hold_seconds to 86400
`include "assert_macros.svh"

module expiring_key_table_with_eviction_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ekt_pkg::PADDR_W-1:0]      paddr,
    input  logic [ekt_pkg::PDATA_W-1:0]      pwdata,
    output logic [ekt_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // key [63:0], now_time [111:64]
    input  logic [ekt_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // command [1:0]
    input  logic [ekt_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // active [0], evicted [1], removed_count [6:2], occupancy [11:7], zero [15:12]
    output logic [ekt_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
    import ekt_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]       occ_reg, occ_next;
    logic [HOLD_W-1:0]      hold_reg;
    logic [CMD_W-1:0]       cmd_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [TIME_W-1:0]      now_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]   out_data_reg, out_data_next;

    logic                   in_acc;
    logic                   out_free;
    logic                   out_load;
    logic                   cfg_hit;
    logic                   cfg_we;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    entry_t                 mem_wdata;
    logic                   rd_vld;
    logic [IDX_W-1:0]       rd_idx;
    entry_t                 rd_entry;
    scan_res_t              scan;
    pick_t                  free_pick;
    pick_t                  exp_pick;
    logic                   out_active;
    logic                   out_evicted;
    logic [CNT_W-1:0]       out_removed;

    // config port
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[PADDR_W-1:2] == '0);
    assign cfg_we  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? PDATA_W'(hold_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= HOLD_RESET;
        else if (cfg_we)
            hold_reg <= pwdata[HOLD_W-1:0];
    end

    // stream handshakes
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg <= s_axis_tuser;
            key_reg <= s_axis_tdata[KEY_W-1:0];
            now_reg <= s_axis_tdata[KEY_W+TIME_W-1:KEY_W];
        end
    end

    ekt_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .we       (mem_we),
        .waddr    (mem_waddr),
        .wdata    (mem_wdata),
        .re       (state_reg == ST_SCAN),
        .raddr    (rd_idx_reg),
        .rd_vld   (rd_vld),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry)
    );

    ekt_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_acc),
        .rd_vld     (rd_vld),
        .rd_idx     (rd_idx),
        .rd_entry   (rd_entry),
        .slot_valid (valid_reg),
        .key        (key_reg),
        .now_time   (now_reg),
        .res        (scan)
    );

    assign free_pick = lowest_set(~valid_reg);
    assign exp_pick  = lowest_set(scan.exp_mask);
    assign mem_wdata = '{key: key_reg, expiry: expiry_of(now_reg, hold_reg)};

    always_comb
    begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        valid_next  = valid_reg;
        occ_next    = occ_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        out_load    = 1'b0;
        out_active  = 1'b0;
        out_evicted = 1'b0;
        out_removed = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    rd_idx_next = '0;
                    state_next  = (s_axis_tuser == CMD_CLEAR) ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_idx_reg == IDX_W'(TABLE_DEPTH - 1))
                    state_next = ST_DRAIN;
                else
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            mem_we = 1'b1;
                            if (scan.match_found)
                                mem_waddr = scan.match_idx;
                            else if (free_pick.any)
                            begin
                                mem_waddr                 = free_pick.idx;
                                valid_next[free_pick.idx] = 1'b1;
                                occ_next                  = occ_reg + CNT_W'(1);
                            end
                            else if (scan.exp_cnt != '0)
                            begin
                                // table full: drop expired, reuse the lowest freed slot
                                mem_waddr                = exp_pick.idx;
                                valid_next               = valid_reg & ~scan.exp_mask;
                                valid_next[exp_pick.idx] = 1'b1;
                                occ_next    = occ_reg - scan.exp_cnt + CNT_W'(1);
                                out_removed = scan.exp_cnt;
                            end
                            else
                            begin
                                mem_waddr   = scan.min_idx;
                                out_evicted = 1'b1;
                            end
                        end
                        CMD_QUERY:
                        begin
                            out_active = scan.match_found && (now_reg < scan.match_exp);
                        end
                        CMD_SWEEP:
                        begin
                            valid_next  = valid_reg & ~scan.exp_mask;
                            occ_next    = occ_reg - scan.exp_cnt;
                            out_removed = scan.exp_cnt;
                        end
                        default:
                        begin
                            valid_next = '0;
                            occ_next   = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = M_TDATA_W'({sat_count(occ_next), sat_count(out_removed),
                                         out_evicted, out_active});
        end
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            valid_reg     <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            valid_reg     <= valid_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    `ASSERT_ALWAYS(a_occ_matches_valid, $countones(valid_reg) == 32'(occ_reg), "occupancy count out of step with valid bits")
    `ASSERT_IMPLIES(a_write_only_on_decide, mem_we, state_reg == ST_DECIDE && out_free, "table write outside decide step")
    `ASSERT_IMPLIES(a_evict_only_when_full, out_load && out_evicted, occ_reg == CNT_W'(TABLE_DEPTH), "eviction with free slots")
    `ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_reg != ST_IDLE, "accepted item did not start processing")

endmodule

[verif/tb_expiring_key_table_with_eviction_unit.sv]
// testbench for the expiring key table: directed and random items checked against a table tracker
`timescale 1ns / 1ps

module tb_expiring_key_table_with_eviction_unit;
    import ekt_pkg::*;

    localparam int                 CYCLE_LIMIT   = 1_000_000;
    localparam int                 SETTLE_CYCLES = 40;
    localparam int                 POOL_SIZE     = 24;
    localparam logic [PADDR_W-1:0] HOLD_ADDR     = PADDR_W'(0);
    localparam logic [TIME_W-1:0]  TIME_MAX      = '1;

    typedef struct packed {
        logic [3:0]         spare;
        logic [COUNT_W-1:0] occupancy;
        logic [COUNT_W-1:0] removed_count;
        logic               evicted;
        logic               active;
    } table_result_t;

    class expiry_table_tracker;
        bit                slot_used [TABLE_DEPTH];
        logic [KEY_W-1:0]  slot_tag [TABLE_DEPTH];
        logic [TIME_W-1:0] slot_deadline [TABLE_DEPTH];
        logic [HOLD_W-1:0] hold;
        table_result_t     pending [$];
        int                mismatches;

        function new();
            hold = HOLD_RESET;
            mismatches = 0;
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
        endfunction

        function int locate(logic [KEY_W-1:0] key);
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (slot_used[i] && slot_tag[i] == key)
                    return i;
            return -1;
        endfunction

        function int first_free();
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (!slot_used[i])
                    return i;
            return -1;
        endfunction

        function int purge(logic [TIME_W-1:0] now);
            int n;
            n = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (slot_used[i] && now >= slot_deadline[i])
                begin
                    slot_used[i] = 1'b0;
                    n++;
                end
            end
            return n;
        endfunction

        function void note_item(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                logic [TIME_W-1:0] now);
            table_result_t     r;
            logic [TIME_W:0]   sum;
            logic [TIME_W-1:0] deadline;
            int                spot;
            int                n;
            r = '0;
            case (cmd)
                CMD_INSERT:
                begin
                    sum = {1'b0, now} + (TIME_W + 1)'(hold);
                    deadline = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                    spot = locate(key);
                    if (spot < 0)
                    begin
                        spot = first_free();
                        if (spot < 0)
                        begin
                            r.removed_count = COUNT_W'(purge(now));
                            spot = first_free();
                        end
                        if (spot < 0)
                        begin
                            spot = 0;
                            for (int i = 1; i < TABLE_DEPTH; i++)
                                if (slot_deadline[i] < slot_deadline[spot])
                                    spot = i;
                            r.evicted = 1'b1;
                        end
                        slot_used[spot] = 1'b1;
                        slot_tag[spot] = key;
                    end
                    slot_deadline[spot] = deadline;
                end
                CMD_QUERY:
                begin
                    spot = locate(key);
                    if (spot >= 0 && now < slot_deadline[spot])
                        r.active = 1'b1;
                end
                CMD_SWEEP:
                    r.removed_count = COUNT_W'(purge(now));
                default:
                    foreach (slot_used[i])
                        slot_used[i] = 1'b0;
            endcase
            n = 0;
            foreach (slot_used[i])
                if (slot_used[i])
                    n++;
            r.occupancy = COUNT_W'(n > COUNT_MAX ? COUNT_MAX : n);
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] raw);
            table_result_t got;
            table_result_t want;
            got = raw;
            if (pending.size() == 0)
            begin
                $display("%0t: result expected none got %h", $time, raw);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            compare_field("active", 8'(want.active), 8'(got.active));
            compare_field("evicted", 8'(want.evicted), 8'(got.evicted));
            compare_field("removed_count", 8'(want.removed_count), 8'(got.removed_count));
            compare_field("occupancy", 8'(want.occupancy), 8'(got.occupancy));
            compare_field("spare bits", 8'(want.spare), 8'(got.spare));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // key [63:0], now_time [111:64]
    logic [S_TDATA_W-1:0] s_axis_tdata;
    // command [1:0]
    logic [CMD_W-1:0]     s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // active [0], evicted [1], removed_count [6:2], occupancy [11:7], zero [15:12]
    logic [M_TDATA_W-1:0] m_axis_tdata;

    expiry_table_tracker  tracker;
    int unsigned          cycle_count;
    int                   burst_left;
    logic [TIME_W-1:0]    sim_seconds;
    logic [KEY_W-1:0]     key_pool [POOL_SIZE];
    logic [KEY_W-1:0]     seed_keys [TABLE_DEPTH];

    expiring_key_table_with_eviction_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // receiver stall pattern rotates through four patterns as the cycle count grows
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_result(m_axis_tdata);
            case ((cycle_count / 500) % 4)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= (cycle_count % 5 == 0);
                default: m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                             input logic [TIME_W-1:0] now);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tdata  <= {now, key};
        s_axis_tuser  <= cmd;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_item(cmd, key, now);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_hold(input logic [HOLD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= HOLD_ADDR;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.hold = value;
    endtask

    task automatic random_items(input int count);
        int unsigned       span;
        int unsigned       step;
        int                pick;
        int                slot;
        logic [TIME_W:0]   later;
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key;
        span = 32'(tracker.hold);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                step = $urandom_range(0, span / 16);
            else if (pick < 90)
                step = $urandom_range(0, span / 2);
            else
                step = $urandom_range(0, span * 2);
            later = {1'b0, sim_seconds} + (TIME_W + 1)'(step);
            sim_seconds = later[TIME_W] ? TIME_MAX : later[TIME_W-1:0];
            pick = $urandom_range(0, 99);
            slot = $urandom_range(0, POOL_SIZE - 1);
            key = key_pool[slot];
            if (pick < 55)
            begin
                cmd = CMD_INSERT;
                if ($urandom_range(0, 99) < 15)
                begin
                    key = random_key();
                    key_pool[slot] = key;
                end
            end
            else if (pick < 90)
            begin
                cmd = CMD_QUERY;
                if ($urandom_range(0, 99) < 20)
                    key = random_key();
            end
            else if (pick < 97)
            begin
                cmd = CMD_SWEEP;
                key = random_key();
            end
            else
            begin
                cmd = CMD_CLEAR;
                key = random_key();
            end
            send_item(cmd, key, sim_seconds);
        end
    endtask

    initial
    begin
        tracker       = new();
        cycle_count   = 0;
        burst_left    = 0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_INSERT;
        m_axis_tready = 1'b0;
        foreach (key_pool[i])
            key_pool[i] = random_key();
        seed_keys[0] = '0;
        seed_keys[1] = '1;
        seed_keys[2] = 64'hAAAA_AAAA_AAAA_AAAA;
        seed_keys[3] = 64'h5555_5555_5555_5555;
        for (int i = 4; i < TABLE_DEPTH; i++)
            seed_keys[i] = random_key();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, then fill with equal expiries and force a tie on eviction
        sim_seconds = '0;
        send_item(CMD_QUERY, seed_keys[0], sim_seconds);
        sim_seconds = 48'd100;
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(CMD_INSERT, seed_keys[i], sim_seconds);
        send_item(CMD_INSERT, 64'h8000_0000_0000_0001, sim_seconds);
        send_item(CMD_QUERY, 64'h8000_0000_0000_0001, sim_seconds);
        send_item(CMD_QUERY, seed_keys[1], sim_seconds);
        // now equal to the expiry: entries count as expired
        sim_seconds = sim_seconds + 48'(HOLD_RESET);
        send_item(CMD_QUERY, seed_keys[1], sim_seconds);
        send_item(CMD_INSERT, seed_keys[2], sim_seconds);
        send_item(CMD_INSERT, 64'h0123_4567_89AB_CDEF, sim_seconds);
        send_item(CMD_SWEEP, '1, sim_seconds);
        send_item(CMD_CLEAR, seed_keys[2], sim_seconds);
        send_item(CMD_SWEEP, '0, sim_seconds);

        random_items(300);
        drain_results();
        write_hold(HOLD_W'(1));
        random_items(300);
        drain_results();
        write_hold('1);
        random_items(300);
        drain_results();
        write_hold(HOLD_W'($urandom_range(2, 500)));
        random_items(300);
        drain_results();
        write_hold(HOLD_W'(37));
        random_items(150);
        drain_results();
        random_items(150);
        drain_results();

        // expiry saturation near the top of the time range
        write_hold('1);
        sim_seconds = TIME_MAX - 48'd3;
        send_item(CMD_INSERT, seed_keys[3], sim_seconds);
        send_item(CMD_QUERY, seed_keys[3], sim_seconds);
        sim_seconds = TIME_MAX;
        send_item(CMD_INSERT, seed_keys[1], sim_seconds);
        send_item(CMD_QUERY, seed_keys[1], sim_seconds);
        send_item(CMD_QUERY, seed_keys[3], sim_seconds);
        sim_seconds = TIME_MAX - 48'd50_000_000;
        random_items(200);
        drain_results();

        if (tracker.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
